// File: design/mhy_pkg.sv
// Shared types, constants and micro-program for the Mahony IMU attitude update block.
package mhy_pkg;

    localparam int F = 30;
    localparam int PC_W = 6;
    localparam int SUB_W = 6;

    localparam logic [63:0] SEVEN_TENTHS_64 = ((64'd7 << F) + 64'd5) / 64'd10;
    localparam logic signed [31:0] Q_RESET_WX = 32'(SEVEN_TENTHS_64);

    localparam logic signed [66:0] ONE_W = 67'sd1 <<< F;
    localparam logic signed [66:0] NEG_ONE_W = -(67'sd1 <<< F);
    localparam logic signed [66:0] SAT40_HI = (67'sd1 <<< 39) - 67'sd1;
    localparam logic signed [66:0] SAT40_LO = -(67'sd1 <<< 39);

    localparam logic [31:0] KP_RESET = 32'd83886080;
    localparam logic [31:0] KI_RESET = 32'd33554;
    localparam logic [31:0] DT_RESET = 32'd42949673;

    localparam logic [1:0] CFG_KP = 2'd0;
    localparam logic [1:0] CFG_KI = 2'd1;
    localparam logic [1:0] CFG_DT = 2'd2;

    // micro-op kinds
    localparam logic [2:0] K_MAC   = 3'd0;
    localparam logic [2:0] K_SQRT  = 3'd1;
    localparam logic [2:0] K_DIV   = 3'd2;
    localparam logic [2:0] K_SCALE = 3'd3;
    localparam logic [2:0] K_SKIP  = 3'd4;
    localparam logic [2:0] K_ZCHK  = 3'd5;
    localparam logic [2:0] K_END   = 3'd6;

    // A operand sources
    localparam logic [4:0] A_Q0 = 5'd0, A_Q1 = 5'd1, A_Q2 = 5'd2, A_Q3 = 5'd3;
    localparam logic [4:0] A_V0 = 5'd4, A_V1 = 5'd5, A_V2 = 5'd6;
    localparam logic [4:0] A_AN0 = 5'd7, A_AN1 = 5'd8, A_AN2 = 5'd9;
    localparam logic [4:0] A_E0 = 5'd10, A_E1 = 5'd11, A_E2 = 5'd12;
    localparam logic [4:0] A_I0 = 5'd13, A_I1 = 5'd14, A_I2 = 5'd15;
    localparam logic [4:0] A_R0 = 5'd16, A_R1 = 5'd17, A_R2 = 5'd18;
    localparam logic [4:0] A_H0 = 5'd19, A_H1 = 5'd20, A_H2 = 5'd21;
    localparam logic [4:0] A_P0 = 5'd22, A_P1 = 5'd23, A_P2 = 5'd24, A_P3 = 5'd25;
    localparam logic [4:0] A_AC0 = 5'd26, A_AC1 = 5'd27, A_AC2 = 5'd28;

    // B operand sources
    localparam logic [4:0] B_Q0 = 5'd0, B_Q1 = 5'd1, B_Q2 = 5'd2, B_Q3 = 5'd3;
    localparam logic [4:0] B_V0 = 5'd4, B_V1 = 5'd5, B_V2 = 5'd6;
    localparam logic [4:0] B_DT = 5'd7, B_KP = 5'd8, B_KI = 5'd9;
    localparam logic [4:0] B_P0 = 5'd10, B_P1 = 5'd11, B_P2 = 5'd12, B_P3 = 5'd13;
    localparam logic [4:0] B_AC0 = 5'd14, B_AC1 = 5'd15, B_AC2 = 5'd16;

    // rounding shifts
    localparam logic [2:0] SH_0 = 3'd0, SH_24 = 3'd1, SH_30 = 3'd2, SH_32 = 3'd3, SH_33 = 3'd4;

    // accumulator start values
    localparam logic [3:0] BS_ZERO = 4'd0, BS_ACC = 4'd1;
    localparam logic [3:0] BS_Q0 = 4'd2, BS_Q1 = 4'd3, BS_Q2 = 4'd4, BS_Q3 = 4'd5;
    localparam logic [3:0] BS_I0 = 4'd6, BS_I1 = 4'd7, BS_I2 = 4'd8;
    localparam logic [3:0] BS_G0 = 4'd9, BS_G1 = 4'd10, BS_G2 = 4'd11;

    // destinations
    localparam logic [4:0] D_NONE = 5'd0;
    localparam logic [4:0] D_V0 = 5'd1, D_V1 = 5'd2, D_V2 = 5'd3;
    localparam logic [4:0] D_SQS = 5'd4, D_SQP = 5'd5;
    localparam logic [4:0] D_AN0 = 5'd6, D_AN1 = 5'd7, D_AN2 = 5'd8;
    localparam logic [4:0] D_E0 = 5'd9, D_E1 = 5'd10, D_E2 = 5'd11;
    localparam logic [4:0] D_I0 = 5'd12, D_I1 = 5'd13, D_I2 = 5'd14;
    localparam logic [4:0] D_R0 = 5'd15, D_R1 = 5'd16, D_R2 = 5'd17;
    localparam logic [4:0] D_H0 = 5'd18, D_H1 = 5'd19, D_H2 = 5'd20;
    localparam logic [4:0] D_P0 = 5'd21, D_P1 = 5'd22, D_P2 = 5'd23, D_P3 = 5'd24;
    localparam logic [4:0] D_Q0 = 5'd25, D_Q1 = 5'd26, D_Q2 = 5'd27, D_Q3 = 5'd28;

    typedef struct packed {
        logic signed [23:0] gyro_x;
        logic signed [23:0] gyro_y;
        logic signed [23:0] gyro_z;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] quat_w;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        logic signed [31:0] gravity_est_x;
        logic signed [31:0] gravity_est_y;
        logic signed [31:0] gravity_est_z;
        logic               update_skipped;
    } t_out_item;

    typedef struct packed {
        logic [2:0] kind;
        logic [4:0] asrc;
        logic [4:0] bsrc;
        logic [2:0] sh;
        logic       neg;
        logic [3:0] base;
        logic [4:0] dest;
    } t_uop;

    function automatic t_uop mac(input logic [4:0] a, input logic [4:0] b,
                                 input logic [2:0] sh, input logic neg,
                                 input logic [3:0] base, input logic [4:0] dest);
        t_uop u;
        u.kind = K_MAC;
        u.asrc = a;
        u.bsrc = b;
        u.sh   = sh;
        u.neg  = neg;
        u.base = base;
        u.dest = dest;
        return u;
    endfunction

    function automatic t_uop ctl(input logic [2:0] kind, input logic [4:0] a,
                                 input logic [4:0] dest);
        t_uop u;
        u      = '0;
        u.kind = kind;
        u.asrc = a;
        u.dest = dest;
        return u;
    endfunction

    function automatic t_uop uop_at(input logic [PC_W-1:0] pc);
        t_uop u;
        case (pc)
            // gravity estimate
            6'd0:  u = mac(A_Q1, B_Q3, SH_30, 1'b0, BS_ZERO, D_NONE);
            6'd1:  u = mac(A_Q0, B_Q2, SH_30, 1'b1, BS_ACC, D_V0);
            6'd2:  u = mac(A_Q0, B_Q1, SH_30, 1'b0, BS_ZERO, D_NONE);
            6'd3:  u = mac(A_Q2, B_Q3, SH_30, 1'b0, BS_ACC, D_V1);
            6'd4:  u = mac(A_Q0, B_Q0, SH_30, 1'b0, BS_ZERO, D_NONE);
            6'd5:  u = mac(A_Q1, B_Q1, SH_30, 1'b1, BS_ACC, D_NONE);
            6'd6:  u = mac(A_Q2, B_Q2, SH_30, 1'b1, BS_ACC, D_NONE);
            6'd7:  u = mac(A_Q3, B_Q3, SH_30, 1'b0, BS_ACC, D_V2);
            6'd8:  u = ctl(K_SKIP, A_Q0, D_NONE);
            // accel normalization
            6'd9:  u = mac(A_AC0, B_AC0, SH_0, 1'b0, BS_ZERO, D_NONE);
            6'd10: u = mac(A_AC1, B_AC1, SH_0, 1'b0, BS_ACC, D_NONE);
            6'd11: u = mac(A_AC2, B_AC2, SH_0, 1'b0, BS_ACC, D_SQS);
            6'd12: u = ctl(K_SQRT, A_Q0, D_NONE);
            6'd13: u = ctl(K_DIV, A_AC0, D_AN0);
            6'd14: u = ctl(K_DIV, A_AC1, D_AN1);
            6'd15: u = ctl(K_DIV, A_AC2, D_AN2);
            // error
            6'd16: u = mac(A_AN1, B_V2, SH_30, 1'b0, BS_ZERO, D_NONE);
            6'd17: u = mac(A_AN2, B_V1, SH_30, 1'b1, BS_ACC, D_E0);
            6'd18: u = mac(A_AN2, B_V0, SH_30, 1'b0, BS_ZERO, D_NONE);
            6'd19: u = mac(A_AN0, B_V2, SH_30, 1'b1, BS_ACC, D_E1);
            6'd20: u = mac(A_AN0, B_V1, SH_30, 1'b0, BS_ZERO, D_NONE);
            6'd21: u = mac(A_AN1, B_V0, SH_30, 1'b1, BS_ACC, D_E2);
            // integral
            6'd22: u = mac(A_E0, B_DT, SH_32, 1'b0, BS_I0, D_I0);
            6'd23: u = mac(A_E1, B_DT, SH_32, 1'b0, BS_I1, D_I1);
            6'd24: u = mac(A_E2, B_DT, SH_32, 1'b0, BS_I2, D_I2);
            // feedback rate
            6'd25: u = mac(A_E0, B_KP, SH_24, 1'b0, BS_G0, D_NONE);
            6'd26: u = mac(A_I0, B_KI, SH_24, 1'b0, BS_ACC, D_R0);
            6'd27: u = mac(A_E1, B_KP, SH_24, 1'b0, BS_G1, D_NONE);
            6'd28: u = mac(A_I1, B_KI, SH_24, 1'b0, BS_ACC, D_R1);
            6'd29: u = mac(A_E2, B_KP, SH_24, 1'b0, BS_G2, D_NONE);
            6'd30: u = mac(A_I2, B_KI, SH_24, 1'b0, BS_ACC, D_R2);
            // half angle increment
            6'd31: u = mac(A_R0, B_DT, SH_33, 1'b0, BS_ZERO, D_H0);
            6'd32: u = mac(A_R1, B_DT, SH_33, 1'b0, BS_ZERO, D_H1);
            6'd33: u = mac(A_R2, B_DT, SH_33, 1'b0, BS_ZERO, D_H2);
            // quaternion product
            6'd34: u = mac(A_H0, B_Q1, SH_30, 1'b1, BS_Q0, D_NONE);
            6'd35: u = mac(A_H1, B_Q2, SH_30, 1'b1, BS_ACC, D_NONE);
            6'd36: u = mac(A_H2, B_Q3, SH_30, 1'b1, BS_ACC, D_P0);
            6'd37: u = mac(A_H0, B_Q0, SH_30, 1'b0, BS_Q1, D_NONE);
            6'd38: u = mac(A_H2, B_Q2, SH_30, 1'b0, BS_ACC, D_NONE);
            6'd39: u = mac(A_H1, B_Q3, SH_30, 1'b1, BS_ACC, D_P1);
            6'd40: u = mac(A_H1, B_Q0, SH_30, 1'b0, BS_Q2, D_NONE);
            6'd41: u = mac(A_H2, B_Q1, SH_30, 1'b1, BS_ACC, D_NONE);
            6'd42: u = mac(A_H0, B_Q3, SH_30, 1'b0, BS_ACC, D_P2);
            6'd43: u = mac(A_H2, B_Q0, SH_30, 1'b0, BS_Q3, D_NONE);
            6'd44: u = mac(A_H1, B_Q1, SH_30, 1'b0, BS_ACC, D_NONE);
            6'd45: u = mac(A_H0, B_Q2, SH_30, 1'b1, BS_ACC, D_P3);
            // renormalization
            6'd46: u = ctl(K_SCALE, A_Q0, D_NONE);
            6'd47: u = mac(A_P0, B_P0, SH_0, 1'b0, BS_ZERO, D_NONE);
            6'd48: u = mac(A_P1, B_P1, SH_0, 1'b0, BS_ACC, D_NONE);
            6'd49: u = mac(A_P2, B_P2, SH_0, 1'b0, BS_ACC, D_NONE);
            6'd50: u = mac(A_P3, B_P3, SH_0, 1'b0, BS_ACC, D_SQP);
            6'd51: u = ctl(K_SQRT, A_Q0, D_NONE);
            6'd52: u = ctl(K_ZCHK, A_Q0, D_NONE);
            6'd53: u = ctl(K_DIV, A_P0, D_Q0);
            6'd54: u = ctl(K_DIV, A_P1, D_Q1);
            6'd55: u = ctl(K_DIV, A_P2, D_Q2);
            6'd56: u = ctl(K_DIV, A_P3, D_Q3);
            default: u = ctl(K_END, A_Q0, D_NONE);
        endcase
        return u;
    endfunction

    function automatic logic signed [31:0] sat_one(input logic signed [66:0] v);
        logic signed [66:0] c;
        c = (v > ONE_W) ? ONE_W : ((v < NEG_ONE_W) ? NEG_ONE_W : v);
        return 32'(c);
    endfunction

    function automatic logic signed [39:0] sat40(input logic signed [66:0] v);
        logic signed [66:0] c;
        c = (v > SAT40_HI) ? SAT40_HI : ((v < SAT40_LO) ? SAT40_LO : v);
        return 40'(c);
    endfunction

endpackage

// File: design/mhy_in_if.sv
// Sample channel: valid/ready handshake carrying one gyro and accelerometer sample.
interface mhy_in_if;
    logic               valid;
    logic               ready;
    mhy_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: design/mhy_out_if.sv
// Result channel: valid/ready handshake carrying one attitude update.
interface mhy_out_if;
    logic               valid;
    logic               ready;
    mhy_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: design/mahony_imu_attitude_update.sv
// Mahony IMU attitude update: sequencer around one shared multiplier, divider and root unit.
//
//  channel   dir  handshake          payload
//  i_in      in   valid/ready        gyro_x..z (Q8.16), accel_x..z (raw)
//  o_out     out  valid/ready        quat_w..z, gravity_est_x..z, update_skipped
//  i_cfg_*   in   write enable only  index 0 kp, 1 ki, 2 dt
//
// One sample runs 45 multiplies on the 16x32 multiply-accumulate unit, two square roots and
// seven divisions on the bit-serial root and divide units, plus skip, scale, zero-norm and end
// steps, a scale step repeated per renormalizing shift, loading the output register and taking
// the sample; an all-zero accelerometer sample stops after the gravity estimate.
// i_in.ready is high only while idle. A finished transfer waits in the output register and the
// next sample is taken meanwhile; a second result waits for that register to free.
// Reset is synchronous; the state returns to its power-on attitude and gains.
module mahony_imu_attitude_update (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mhy_in_if.sink        i_in,
    mhy_out_if.source     o_out,
    input  logic          i_cfg_wr_en,
    input  logic [1:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_wdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                 r_state;
    logic [mhy_pkg::PC_W-1:0]   r_pc;
    logic [mhy_pkg::SUB_W-1:0]  r_sub;

    logic [31:0]        r_kp, r_ki, r_dt;
    logic signed [31:0] r_q [4];
    logic signed [39:0] r_int [3];
    logic signed [23:0] r_g [3];
    logic signed [15:0] r_a [3];
    logic               r_skip;
    logic signed [31:0] r_v [3];
    logic signed [31:0] r_an [3];
    logic signed [33:0] r_e [3];
    logic signed [39:0] r_rate [3];
    logic signed [39:0] r_h [3];
    logic [41:0]        r_pm [4];
    logic               r_ps [4];
    logic signed [65:0] r_acc;

    logic [47:0]        r_ma;
    logic [31:0]        r_mb;
    logic               r_neg;
    logic [79:0]        r_prod;

    logic [63:0]        r_rad;
    logic [63:0]        r_srad;
    logic [35:0]        r_srem;
    logic [31:0]        r_root;

    logic [32:0]        r_drem;
    logic [30:0]        r_dlow;
    logic [30:0]        r_quo;
    logic               r_dneg;

    logic                r_out_vld;
    mhy_pkg::t_out_item  r_out;

    mhy_pkg::t_uop      uop;
    logic signed [47:0] a_val;
    logic signed [33:0] b_val;
    logic [47:0]        a_mag;
    logic [31:0]        b_mag;
    logic [47:0]        pp;
    logic [79:0]        rnd;
    logic [63:0]        term_mag;
    logic signed [65:0] term;
    logic signed [65:0] base_val;
    logic signed [65:0] acc_new;
    logic [63:0]        d_num;
    logic               d_neg;
    logic [33:0]        d_try;
    logic [35:0]        s_sh;
    logic [35:0]        s_trial;
    logic [31:0]        d_res_mag;
    logic signed [31:0] d_res;
    logic [41:0]        pm_or;
    logic               out_free;

    assign uop = mhy_pkg::uop_at(r_pc);
    assign out_free = !r_out_vld || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE);
    assign o_out.valid = r_out_vld;
    assign o_out.data = r_out;

    always_comb begin
        case (uop.asrc)
            mhy_pkg::A_Q0:  a_val = 48'(r_q[0]);
            mhy_pkg::A_Q1:  a_val = 48'(r_q[1]);
            mhy_pkg::A_Q2:  a_val = 48'(r_q[2]);
            mhy_pkg::A_Q3:  a_val = 48'(r_q[3]);
            mhy_pkg::A_V0:  a_val = 48'(r_v[0]);
            mhy_pkg::A_V1:  a_val = 48'(r_v[1]);
            mhy_pkg::A_V2:  a_val = 48'(r_v[2]);
            mhy_pkg::A_AN0: a_val = 48'(r_an[0]);
            mhy_pkg::A_AN1: a_val = 48'(r_an[1]);
            mhy_pkg::A_AN2: a_val = 48'(r_an[2]);
            mhy_pkg::A_E0:  a_val = 48'(r_e[0]);
            mhy_pkg::A_E1:  a_val = 48'(r_e[1]);
            mhy_pkg::A_E2:  a_val = 48'(r_e[2]);
            mhy_pkg::A_I0:  a_val = 48'(r_int[0]);
            mhy_pkg::A_I1:  a_val = 48'(r_int[1]);
            mhy_pkg::A_I2:  a_val = 48'(r_int[2]);
            mhy_pkg::A_R0:  a_val = 48'(r_rate[0]);
            mhy_pkg::A_R1:  a_val = 48'(r_rate[1]);
            mhy_pkg::A_R2:  a_val = 48'(r_rate[2]);
            mhy_pkg::A_H0:  a_val = 48'(r_h[0]);
            mhy_pkg::A_H1:  a_val = 48'(r_h[1]);
            mhy_pkg::A_H2:  a_val = 48'(r_h[2]);
            mhy_pkg::A_P0:  a_val = $signed({6'd0, r_pm[0]});
            mhy_pkg::A_P1:  a_val = $signed({6'd0, r_pm[1]});
            mhy_pkg::A_P2:  a_val = $signed({6'd0, r_pm[2]});
            mhy_pkg::A_P3:  a_val = $signed({6'd0, r_pm[3]});
            mhy_pkg::A_AC0: a_val = 48'(r_a[0]);
            mhy_pkg::A_AC1: a_val = 48'(r_a[1]);
            mhy_pkg::A_AC2: a_val = 48'(r_a[2]);
            default:        a_val = '0;
        endcase
    end

    always_comb begin
        case (uop.bsrc)
            mhy_pkg::B_Q0:  b_val = 34'(r_q[0]);
            mhy_pkg::B_Q1:  b_val = 34'(r_q[1]);
            mhy_pkg::B_Q2:  b_val = 34'(r_q[2]);
            mhy_pkg::B_Q3:  b_val = 34'(r_q[3]);
            mhy_pkg::B_V0:  b_val = 34'(r_v[0]);
            mhy_pkg::B_V1:  b_val = 34'(r_v[1]);
            mhy_pkg::B_V2:  b_val = 34'(r_v[2]);
            mhy_pkg::B_DT:  b_val = $signed({2'b00, r_dt});
            mhy_pkg::B_KP:  b_val = $signed({2'b00, r_kp});
            mhy_pkg::B_KI:  b_val = $signed({2'b00, r_ki});
            mhy_pkg::B_P0:  b_val = $signed({3'b000, r_pm[0][30:0]});
            mhy_pkg::B_P1:  b_val = $signed({3'b000, r_pm[1][30:0]});
            mhy_pkg::B_P2:  b_val = $signed({3'b000, r_pm[2][30:0]});
            mhy_pkg::B_P3:  b_val = $signed({3'b000, r_pm[3][30:0]});
            mhy_pkg::B_AC0: b_val = 34'(r_a[0]);
            mhy_pkg::B_AC1: b_val = 34'(r_a[1]);
            mhy_pkg::B_AC2: b_val = 34'(r_a[2]);
            default:        b_val = '0;
        endcase
    end

    always_comb begin
        case (uop.base)
            mhy_pkg::BS_ZERO: base_val = '0;
            mhy_pkg::BS_ACC:  base_val = r_acc;
            mhy_pkg::BS_Q0:   base_val = 66'(r_q[0]);
            mhy_pkg::BS_Q1:   base_val = 66'(r_q[1]);
            mhy_pkg::BS_Q2:   base_val = 66'(r_q[2]);
            mhy_pkg::BS_Q3:   base_val = 66'(r_q[3]);
            mhy_pkg::BS_I0:   base_val = 66'(r_int[0]);
            mhy_pkg::BS_I1:   base_val = 66'(r_int[1]);
            mhy_pkg::BS_I2:   base_val = 66'(r_int[2]);
            mhy_pkg::BS_G0:   base_val = 66'(r_g[0]) <<< (mhy_pkg::F - 16);
            mhy_pkg::BS_G1:   base_val = 66'(r_g[1]) <<< (mhy_pkg::F - 16);
            mhy_pkg::BS_G2:   base_val = 66'(r_g[2]) <<< (mhy_pkg::F - 16);
            default:          base_val = '0;
        endcase
    end

    always_comb begin
        a_mag = a_val[47] ? 48'(-a_val) : 48'(a_val);
        b_mag = b_val[33] ? 32'(-b_val) : 32'(b_val);
        pp = r_ma[47:32] * r_mb;
        case (uop.sh)
            mhy_pkg::SH_0: begin
                rnd = r_prod;
                term_mag = rnd[63:0];
            end
            mhy_pkg::SH_24: begin
                rnd = r_prod + (80'd1 << 23);
                term_mag = 64'(rnd >> 24);
            end
            mhy_pkg::SH_30: begin
                rnd = r_prod + (80'd1 << 29);
                term_mag = 64'(rnd >> 30);
            end
            mhy_pkg::SH_32: begin
                rnd = r_prod + (80'd1 << 31);
                term_mag = 64'(rnd >> 32);
            end
            mhy_pkg::SH_33: begin
                rnd = r_prod + (80'd1 << 32);
                term_mag = 64'(rnd >> 33);
            end
            default: begin
                rnd = r_prod;
                term_mag = rnd[63:0];
            end
        endcase
        term = $signed({2'b00, term_mag});
        acc_new = (r_neg ^ uop.neg) ? base_val - term : base_val + term;
    end

    // divider numerator, sign, trial value and signed result; root shift and trial; OR of product magnitudes
    always_comb begin
        case (uop.asrc)
            mhy_pkg::A_AC0: begin
                d_num = {2'b00, (r_a[0][15] ? 16'(-r_a[0]) : 16'(r_a[0])), 46'd0};
                d_neg = r_a[0][15];
            end
            mhy_pkg::A_AC1: begin
                d_num = {2'b00, (r_a[1][15] ? 16'(-r_a[1]) : 16'(r_a[1])), 46'd0};
                d_neg = r_a[1][15];
            end
            mhy_pkg::A_AC2: begin
                d_num = {2'b00, (r_a[2][15] ? 16'(-r_a[2]) : 16'(r_a[2])), 46'd0};
                d_neg = r_a[2][15];
            end
            mhy_pkg::A_P0: begin
                d_num = {3'b000, r_pm[0][30:0], 30'd0};
                d_neg = r_ps[0];
            end
            mhy_pkg::A_P1: begin
                d_num = {3'b000, r_pm[1][30:0], 30'd0};
                d_neg = r_ps[1];
            end
            mhy_pkg::A_P2: begin
                d_num = {3'b000, r_pm[2][30:0], 30'd0};
                d_neg = r_ps[2];
            end
            mhy_pkg::A_P3: begin
                d_num = {3'b000, r_pm[3][30:0], 30'd0};
                d_neg = r_ps[3];
            end
            default: begin
                d_num = '0;
                d_neg = 1'b0;
            end
        endcase
        d_try = {r_drem, r_dlow[30]};
        d_res_mag = {1'b0, r_quo};
        d_res = r_dneg ? -$signed(d_res_mag) : $signed(d_res_mag);
        s_sh = {r_srem[33:0], r_srad[63:62]};
        s_trial = {2'b00, r_root, 2'b01};
        pm_or = r_pm[0] | r_pm[1] | r_pm[2] | r_pm[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pc      <= '0;
            r_sub     <= '0;
            r_out_vld <= 1'b0;
            r_kp      <= mhy_pkg::KP_RESET;
            r_ki      <= mhy_pkg::KI_RESET;
            r_dt      <= mhy_pkg::DT_RESET;
            r_q[0]    <= mhy_pkg::Q_RESET_WX;
            r_q[1]    <= mhy_pkg::Q_RESET_WX;
            r_q[2]    <= '0;
            r_q[3]    <= '0;
            r_int[0]  <= '0;
            r_int[1]  <= '0;
            r_int[2]  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    mhy_pkg::CFG_KP: r_kp <= i_cfg_wdata;
                    mhy_pkg::CFG_KI: r_ki <= i_cfg_wdata;
                    mhy_pkg::CFG_DT: r_dt <= i_cfg_wdata;
                    default: ;
                endcase
            end

            if (r_out_vld && o_out.ready && (r_state != ST_DONE)) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_g[0] <= i_in.data.gyro_x;
                        r_g[1] <= i_in.data.gyro_y;
                        r_g[2] <= i_in.data.gyro_z;
                        r_a[0] <= i_in.data.accel_x;
                        r_a[1] <= i_in.data.accel_y;
                        r_a[2] <= i_in.data.accel_z;
                        r_skip <= (i_in.data.accel_x == '0) && (i_in.data.accel_y == '0)
                                  && (i_in.data.accel_z == '0);
                        r_pc    <= '0;
                        r_sub   <= '0;
                        r_state <= ST_RUN;
                    end
                end

                ST_RUN: begin
                    case (uop.kind)
                        mhy_pkg::K_MAC: begin
                            if (r_sub == 6'd0) begin
                                r_ma   <= a_mag;
                                r_mb   <= b_mag;
                                r_neg  <= a_val[47] ^ b_val[33];
                                r_prod <= '0;
                                r_sub  <= r_sub + 6'd1;
                            end else if (r_sub != 6'd4) begin
                                r_prod <= {r_prod[63:0], 16'd0} + 80'(pp);
                                r_ma   <= {r_ma[31:0], 16'd0};
                                r_sub  <= r_sub + 6'd1;
                            end else begin
                                r_acc <= acc_new;
                                case (uop.dest)
                                    mhy_pkg::D_V0:  r_v[0] <= mhy_pkg::sat_one(67'(acc_new) <<< 1);
                                    mhy_pkg::D_V1:  r_v[1] <= mhy_pkg::sat_one(67'(acc_new) <<< 1);
                                    mhy_pkg::D_V2:  r_v[2] <= mhy_pkg::sat_one(67'(acc_new));
                                    mhy_pkg::D_SQS: r_rad <= {acc_new[31:0], 32'd0};
                                    mhy_pkg::D_SQP: r_rad <= acc_new[63:0];
                                    mhy_pkg::D_E0:  r_e[0] <= 34'(acc_new);
                                    mhy_pkg::D_E1:  r_e[1] <= 34'(acc_new);
                                    mhy_pkg::D_E2:  r_e[2] <= 34'(acc_new);
                                    mhy_pkg::D_I0:  r_int[0] <= mhy_pkg::sat40(67'(acc_new));
                                    mhy_pkg::D_I1:  r_int[1] <= mhy_pkg::sat40(67'(acc_new));
                                    mhy_pkg::D_I2:  r_int[2] <= mhy_pkg::sat40(67'(acc_new));
                                    mhy_pkg::D_R0:  r_rate[0] <= mhy_pkg::sat40(67'(acc_new));
                                    mhy_pkg::D_R1:  r_rate[1] <= mhy_pkg::sat40(67'(acc_new));
                                    mhy_pkg::D_R2:  r_rate[2] <= mhy_pkg::sat40(67'(acc_new));
                                    mhy_pkg::D_H0:  r_h[0] <= 40'(acc_new);
                                    mhy_pkg::D_H1:  r_h[1] <= 40'(acc_new);
                                    mhy_pkg::D_H2:  r_h[2] <= 40'(acc_new);
                                    mhy_pkg::D_P0: begin
                                        r_pm[0] <= acc_new[65] ? 42'(-acc_new) : 42'(acc_new);
                                        r_ps[0] <= acc_new[65];
                                    end
                                    mhy_pkg::D_P1: begin
                                        r_pm[1] <= acc_new[65] ? 42'(-acc_new) : 42'(acc_new);
                                        r_ps[1] <= acc_new[65];
                                    end
                                    mhy_pkg::D_P2: begin
                                        r_pm[2] <= acc_new[65] ? 42'(-acc_new) : 42'(acc_new);
                                        r_ps[2] <= acc_new[65];
                                    end
                                    mhy_pkg::D_P3: begin
                                        r_pm[3] <= acc_new[65] ? 42'(-acc_new) : 42'(acc_new);
                                        r_ps[3] <= acc_new[65];
                                    end
                                    default: ;
                                endcase
                                r_sub <= '0;
                                r_pc  <= r_pc + 6'd1;
                            end
                        end

                        mhy_pkg::K_SQRT: begin
                            if (r_sub == 6'd0) begin
                                r_srad <= r_rad;
                                r_srem <= '0;
                                r_root <= '0;
                                r_sub  <= r_sub + 6'd1;
                            end else begin
                                r_srad <= {r_srad[61:0], 2'b00};
                                if (s_sh >= s_trial) begin
                                    r_srem <= s_sh - s_trial;
                                    r_root <= {r_root[30:0], 1'b1};
                                end else begin
                                    r_srem <= s_sh;
                                    r_root <= {r_root[30:0], 1'b0};
                                end
                                if (r_sub == 6'd32) begin
                                    r_sub <= '0;
                                    r_pc  <= r_pc + 6'd1;
                                end else begin
                                    r_sub <= r_sub + 6'd1;
                                end
                            end
                        end

                        mhy_pkg::K_DIV: begin
                            if (r_sub == 6'd0) begin
                                r_drem <= d_num[63:31];
                                r_dlow <= d_num[30:0];
                                r_dneg <= d_neg;
                                r_quo  <= '0;
                                r_sub  <= r_sub + 6'd1;
                            end else if (r_sub != 6'd32) begin
                                r_dlow <= {r_dlow[29:0], 1'b0};
                                if (d_try >= {2'b00, r_root}) begin
                                    r_drem <= 33'(d_try - {2'b00, r_root});
                                    r_quo  <= {r_quo[29:0], 1'b1};
                                end else begin
                                    r_drem <= d_try[32:0];
                                    r_quo  <= {r_quo[29:0], 1'b0};
                                end
                                r_sub <= r_sub + 6'd1;
                            end else begin
                                case (uop.dest)
                                    mhy_pkg::D_AN0: r_an[0] <= d_res;
                                    mhy_pkg::D_AN1: r_an[1] <= d_res;
                                    mhy_pkg::D_AN2: r_an[2] <= d_res;
                                    mhy_pkg::D_Q0:  r_q[0] <= mhy_pkg::sat_one(67'(d_res));
                                    mhy_pkg::D_Q1:  r_q[1] <= mhy_pkg::sat_one(67'(d_res));
                                    mhy_pkg::D_Q2:  r_q[2] <= mhy_pkg::sat_one(67'(d_res));
                                    mhy_pkg::D_Q3:  r_q[3] <= mhy_pkg::sat_one(67'(d_res));
                                    default: ;
                                endcase
                                r_sub <= '0;
                                r_pc  <= r_pc + 6'd1;
                            end
                        end

                        mhy_pkg::K_SCALE: begin
                            if (pm_or[41:31] != '0) begin
                                r_pm[0] <= r_pm[0] >> 1;
                                r_pm[1] <= r_pm[1] >> 1;
                                r_pm[2] <= r_pm[2] >> 1;
                                r_pm[3] <= r_pm[3] >> 1;
                            end else begin
                                r_pc <= r_pc + 6'd1;
                            end
                        end

                        mhy_pkg::K_SKIP: begin
                            if (r_skip) begin
                                r_state <= ST_DONE;
                            end else begin
                                r_pc <= r_pc + 6'd1;
                            end
                        end

                        mhy_pkg::K_ZCHK: begin
                            if (r_root == '0) begin
                                r_state <= ST_DONE;
                            end else begin
                                r_pc <= r_pc + 6'd1;
                            end
                        end

                        default: begin
                            r_state <= ST_DONE;
                        end
                    endcase
                end

                ST_DONE: begin
                    if (out_free) begin
                        r_out.quat_w         <= r_q[0];
                        r_out.quat_x         <= r_q[1];
                        r_out.quat_y         <= r_q[2];
                        r_out.quat_z         <= r_q[3];
                        r_out.gravity_est_x  <= r_v[0];
                        r_out.gravity_est_y  <= r_v[1];
                        r_out.gravity_est_z  <= r_v[2];
                        r_out.update_skipped <= r_skip;
                        r_out_vld            <= 1'b1;
                        r_state              <= ST_IDLE;
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: sim/tb_mhy_chan_if.sv
// Testbench-wide constants: run length limit.
`timescale 1ns / 100ps
package tb_mhy_util_pkg;
    localparam int TB_MAX_CYCLES = 4000000;
endpackage

// File: sim/tb_top.sv
// Testbench for the Mahony IMU attitude update: bit-exact predictor, random traffic and gains.
`timescale 1ns / 100ps
module tb_top;

    typedef longint signed t_s64;

    function automatic t_s64 iabs(t_s64 v);
        return v < 0 ? -v : v;
    endfunction

    function automatic t_s64 clampq(t_s64 v, t_s64 lo, t_s64 hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // round(a*b/2^n), ties away from zero
    function automatic t_s64 rmul(t_s64 a, t_s64 b, int n);
        logic [127:0] p;
        logic [127:0] r;
        bit neg;
        neg = (a < 0) != (b < 0);
        p = 128'(iabs(a)) * 128'(iabs(b));
        r = (p + (128'd1 << (n - 1))) >> n;
        return neg ? -t_s64'(r) : t_s64'(r);
    endfunction

    function automatic logic [63:0] fsqrt(logic [63:0] v);
        logic [63:0] r, b;
        r = '0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_s64 sdiv(t_s64 num, int sh, logic [63:0] den);
        logic [127:0] q;
        q = (128'(iabs(num)) << sh) / 128'(den);
        return num < 0 ? -t_s64'(q) : t_s64'(q);
    endfunction

    class attitude_scoreboard;
        t_s64 quat[4];
        t_s64 integ[3];
        logic [31:0] kp, ki, dt;
        mhy_pkg::t_out_item pending[$];
        int errors;
        int n_checked;
        int n_skipped;

        function new();
            quat[0] = t_s64'(mhy_pkg::Q_RESET_WX);
            quat[1] = t_s64'(mhy_pkg::Q_RESET_WX);
            quat[2] = 0;
            quat[3] = 0;
            integ[0] = 0; integ[1] = 0; integ[2] = 0;
            kp = mhy_pkg::KP_RESET; ki = mhy_pkg::KI_RESET; dt = mhy_pkg::DT_RESET;
            errors = 0; n_checked = 0; n_skipped = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            if (idx == mhy_pkg::CFG_KP) kp = val;
            else if (idx == mhy_pkg::CFG_KI) ki = val;
            else if (idx == mhy_pkg::CFG_DT) dt = val;
        endfunction

        function void note_sample(mhy_pkg::t_in_item s);
            t_s64 g[3], a[3], an[3], v[3], e[3], r[3], h[3], p[4];
            t_s64 w, x, y, z, one, hi40, lo40;
            logic [63:0] sq, r16, ps, nr, m;
            int k;
            mhy_pkg::t_out_item o;
            one = t_s64'(1) << mhy_pkg::F;
            hi40 = (t_s64'(1) << 39) - 1;
            lo40 = -(t_s64'(1) << 39);
            g[0] = t_s64'(s.gyro_x); g[1] = t_s64'(s.gyro_y); g[2] = t_s64'(s.gyro_z);
            a[0] = t_s64'(s.accel_x); a[1] = t_s64'(s.accel_y); a[2] = t_s64'(s.accel_z);
            w = quat[0]; x = quat[1]; y = quat[2]; z = quat[3];
            v[0] = 2 * (rmul(x, z, mhy_pkg::F) - rmul(w, y, mhy_pkg::F));
            v[1] = 2 * (rmul(w, x, mhy_pkg::F) + rmul(y, z, mhy_pkg::F));
            v[2] = rmul(w, w, mhy_pkg::F) - rmul(x, x, mhy_pkg::F) - rmul(y, y, mhy_pkg::F)
                 + rmul(z, z, mhy_pkg::F);
            for (int i = 0; i < 3; i++) v[i] = clampq(v[i], -one, one);
            o.update_skipped = (a[0] == 0 && a[1] == 0 && a[2] == 0);
            if (!o.update_skipped) begin
                sq = 64'(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
                r16 = fsqrt(sq << 32);
                for (int i = 0; i < 3; i++) an[i] = sdiv(a[i], mhy_pkg::F + 16, r16);
                e[0] = rmul(an[1], v[2], mhy_pkg::F) - rmul(an[2], v[1], mhy_pkg::F);
                e[1] = rmul(an[2], v[0], mhy_pkg::F) - rmul(an[0], v[2], mhy_pkg::F);
                e[2] = rmul(an[0], v[1], mhy_pkg::F) - rmul(an[1], v[0], mhy_pkg::F);
                for (int i = 0; i < 3; i++) begin
                    integ[i] = clampq(integ[i] + rmul(e[i], t_s64'(dt), 32), lo40, hi40);
                    r[i] = g[i] * (t_s64'(1) << (mhy_pkg::F - 16)) + rmul(e[i], t_s64'(kp), 24)
                         + rmul(integ[i], t_s64'(ki), 24);
                    r[i] = clampq(r[i], lo40, hi40);
                    h[i] = rmul(r[i], t_s64'(dt), 33);
                end
                p[0] = w - rmul(h[0], x, mhy_pkg::F) - rmul(h[1], y, mhy_pkg::F)
                     - rmul(h[2], z, mhy_pkg::F);
                p[1] = x + rmul(h[0], w, mhy_pkg::F) + rmul(h[2], y, mhy_pkg::F)
                     - rmul(h[1], z, mhy_pkg::F);
                p[2] = y + rmul(h[1], w, mhy_pkg::F) - rmul(h[2], x, mhy_pkg::F)
                     + rmul(h[0], z, mhy_pkg::F);
                p[3] = z + rmul(h[2], w, mhy_pkg::F) + rmul(h[1], x, mhy_pkg::F)
                     - rmul(h[0], y, mhy_pkg::F);
                m = '0;
                for (int i = 0; i < 4; i++) if (64'(iabs(p[i])) > m) m = 64'(iabs(p[i]));
                k = 0;
                while ((m >> k) >= (64'd1 << 31)) k++;
                ps = '0;
                for (int i = 0; i < 4; i++) begin
                    t_s64 pm;
                    pm = iabs(p[i]) >>> k;
                    p[i] = p[i] < 0 ? -pm : pm;
                    ps += 64'(pm) * 64'(pm);
                end
                nr = fsqrt(ps);
                if (nr != 0)
                    for (int i = 0; i < 4; i++)
                        quat[i] = clampq(sdiv(p[i], mhy_pkg::F, nr), -one, one);
            end
            o.quat_w = 32'(quat[0]); o.quat_x = 32'(quat[1]);
            o.quat_y = 32'(quat[2]); o.quat_z = 32'(quat[3]);
            o.gravity_est_x = 32'(v[0]); o.gravity_est_y = 32'(v[1]);
            o.gravity_est_z = 32'(v[2]);
            pending.push_back(o);
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %0d: %s got %0d want %0d", n_checked, what, got, want);
            errors++;
        endtask

        task check_result(mhy_pkg::t_out_item o);
            mhy_pkg::t_out_item x;
            if (pending.size() == 0) begin
                report("unexpected transfer", 1, 0);
                return;
            end
            x = pending.pop_front();
            if (o.quat_w !== x.quat_w) report("quat_w", o.quat_w, x.quat_w);
            if (o.quat_x !== x.quat_x) report("quat_x", o.quat_x, x.quat_x);
            if (o.quat_y !== x.quat_y) report("quat_y", o.quat_y, x.quat_y);
            if (o.quat_z !== x.quat_z) report("quat_z", o.quat_z, x.quat_z);
            if (o.gravity_est_x !== x.gravity_est_x)
                report("gravity_est_x", o.gravity_est_x, x.gravity_est_x);
            if (o.gravity_est_y !== x.gravity_est_y)
                report("gravity_est_y", o.gravity_est_y, x.gravity_est_y);
            if (o.gravity_est_z !== x.gravity_est_z)
                report("gravity_est_z", o.gravity_est_z, x.gravity_est_z);
            if (o.update_skipped !== x.update_skipped)
                report("update_skipped", o.update_skipped, x.update_skipped);
            if (x.update_skipped) n_skipped++;
            n_checked++;
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [1:0] i_cfg_index;
    logic [31:0] i_cfg_wdata;
    mhy_in_if sample_ch();
    mhy_out_if update_ch();

    attitude_scoreboard sb;
    int cycle_count = 0;
    int hold_stretch = 0;
    bit hold_done = 1'b0;
    bit hold_go;
    bit calm_tx, calm_rx;
    int n_sent;

    mahony_imu_attitude_update DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(sample_ch.sink), .o_out(update_ch.source),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_index(i_cfg_index), .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > tb_mhy_util_pkg::TB_MAX_CYCLES) begin
            $display("timeout");
            $display("tb_top: errors");
            $finish;
        end
    end

    // receiver: accepts at rising edge, changes ready at falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && update_ch.valid && update_ch.ready) sb.check_result(update_ch.data);
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            update_ch.ready <= 1'b0;
        end else if (hold_go && !hold_done) begin
            hold_done <= 1'b1;
            hold_stretch <= 3000;
            update_ch.ready <= 1'b0;
        end else if (hold_stretch > 0) begin
            hold_stretch <= hold_stretch - 1;
            update_ch.ready <= 1'b0;
        end else begin
            update_ch.ready <= calm_rx ? 1'b1 : ($urandom_range(99) >= 30);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    // entered and left at a falling edge; valid stays up after a transfer until the next
    // call or a drain lowers it
    task automatic send_sample(mhy_pkg::t_in_item s);
        while (!calm_tx && $urandom_range(99) < 30) begin
            sample_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.data <= s;
        @(posedge i_clk);
        while (!sample_ch.ready) @(posedge i_clk);
        sb.note_sample(s);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        sample_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (600) @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_accel();
        case ($urandom_range(5))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'($urandom_range(3)) - 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic mhy_pkg::t_in_item rand_sample();
        mhy_pkg::t_in_item s;
        s.gyro_x = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($signed(17'($urandom)));
        s.gyro_y = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($signed(17'($urandom)));
        s.gyro_z = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($signed(17'($urandom)));
        if ($urandom_range(19) == 0) begin
            s.accel_x = '0; s.accel_y = '0; s.accel_z = '0;
        end else begin
            s.accel_x = rand_accel(); s.accel_y = rand_accel(); s.accel_z = rand_accel();
        end
        return s;
    endfunction

    function automatic mhy_pkg::t_in_item mk(int gx, int gy, int gz, int ax, int ay, int az);
        mhy_pkg::t_in_item s;
        s.gyro_x = 24'(gx); s.gyro_y = 24'(gy); s.gyro_z = 24'(gz);
        s.accel_x = 16'(ax); s.accel_y = 16'(ay); s.accel_z = 16'(az);
        return s;
    endfunction

    initial begin
        logic [31:0] kp_set[4], ki_set[4], dt_set[4];
        sb = new();
        n_sent = 0;
        hold_go = 1'b0;
        calm_tx = 0;
        calm_rx = 0;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = mhy_pkg::CFG_KP;
        i_cfg_wdata = '0;
        sample_ch.valid = 1'b0;
        sample_ch.data = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, zero accel, zero period, saturating gains
        send_sample(mk(0, 0, 0, 0, 0, 16384));
        send_sample(mk(0, 0, 0, 0, 0, 0));
        send_sample(mk(8388607, 8388607, 8388607, 32767, 32767, 32767));
        send_sample(mk(-8388608, -8388608, -8388608, -32768, -32768, -32768));
        send_sample(mk(65536, -65536, 0, 1, 0, 0));
        send_sample(mk(0, 0, 0, 0, -1, 0));
        send_sample(mk(-1, 1, -1, 32767, -32768, 0));
        drain();
        write_reg(mhy_pkg::CFG_DT, 32'd0);
        send_sample(mk(65536, 65536, 65536, 100, 200, 300));
        send_sample(mk(0, 0, 0, 0, 0, 0));
        drain();
        write_reg(mhy_pkg::CFG_KP, 32'hFFFF_FFFF);
        write_reg(mhy_pkg::CFG_KI, 32'hFFFF_FFFF);
        write_reg(mhy_pkg::CFG_DT, 32'hFFFF_FFFF);
        for (int i = 0; i < 8; i++) send_sample(rand_sample());
        send_sample(mk(8388607, -8388608, 8388607, -32768, 32767, -32768));
        drain();

        kp_set = '{mhy_pkg::KP_RESET, 32'd0, 32'hFFFF_FFFF, 32'd16777216};
        ki_set = '{mhy_pkg::KI_RESET, 32'hFFFF_FFFF, 32'd0, 32'd1677722};
        dt_set = '{mhy_pkg::DT_RESET, 32'd1, 32'hFFFF_FFFF, 32'd4294967};
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(mhy_pkg::CFG_KP, kp_set[ph]);
            write_reg(mhy_pkg::CFG_KI, ki_set[ph]);
            write_reg(mhy_pkg::CFG_DT, dt_set[ph]);
            calm_tx = (ph == 1);
            calm_rx = (ph == 1);
            if (ph == 2) hold_go = 1'b1;
            for (int i = 0; i < 380; i++) send_sample(rand_sample());
            drain();
        end

        $display("sent %0d samples, checked %0d updates (%0d skipped) over 6 gain settings",
                 n_sent, sb.n_checked, sb.n_skipped);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule
